// ----- hw/rtl/tndf_pkg.sv -----
`timescale 1ns / 1ps

package tndf_pkg;

	localparam int VAL_W  = 16;
	localparam int NUM_W  = 13;
	localparam int CODE_W = 4;

	localparam int TOP_LIMIT    = 1999;
	localparam int BOTTOM_LIMIT = 999;
	localparam int DECIMAL_LOW  = -99;
	localparam int ONE_LOW      = 1000;
	localparam int ROUND_HALF   = 5;

	localparam logic [CODE_W-1:0] CODE_L     = 4'd10;
	localparam logic [CODE_W-1:0] CODE_O     = 4'd11;
	localparam logic [CODE_W-1:0] CODE_H     = 4'd12;
	localparam logic [CODE_W-1:0] CODE_I     = 4'd13;
	localparam logic [CODE_W-1:0] CODE_MINUS = 4'd14;
	localparam logic [CODE_W-1:0] CODE_BLANK = 4'd15;

	// Number after the tenths/units decision, with its row and dot flag
	typedef struct packed {
		logic signed [NUM_W-1:0] n;
		logic                    top;
		logic                    dot;
	} num_t;

	// One formatted display row
	typedef struct packed {
		logic [CODE_W-1:0] left;
		logic [CODE_W-1:0] middle;
		logic [CODE_W-1:0] right;
		logic              dot;
		logic              one_on;
		logic              one_write;
	} disp_t;

endpackage

// ----- hw/rtl/tndf_in_if.sv -----
`timescale 1ns / 1ps

interface tndf_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [tndf_pkg::VAL_W-1:0]    value_tenths;
	logic                                 top_row;

	modport source (output valid, output value_tenths, output top_row, input ready);
	modport sink   (input valid, input value_tenths, input top_row, output ready);
endinterface

// ----- hw/rtl/tndf_out_if.sv -----
`timescale 1ns / 1ps

interface tndf_out_if;
	logic                          valid;
	logic                          ready;
	logic [tndf_pkg::CODE_W-1:0]   char_left;
	logic [tndf_pkg::CODE_W-1:0]   char_middle;
	logic [tndf_pkg::CODE_W-1:0]   char_right;
	logic                          dot_on;
	logic                          leading_one_on;
	logic                          leading_one_write;

	modport source (output valid, output char_left, output char_middle, output char_right,
		output dot_on, output leading_one_on, output leading_one_write, input ready);
	modport sink   (input valid, input char_left, input char_middle, input char_right,
		input dot_on, input leading_one_on, input leading_one_write, output ready);
endinterface

// ----- hw/rtl/tndf_round.sv -----
`timescale 1ns / 1ps

module tndf_round (
	input  logic signed [tndf_pkg::VAL_W-1:0] value_tenths,
	input  logic                              top_row,
	output tndf_pkg::num_t                    num
);

	localparam logic signed [tndf_pkg::VAL_W-1:0] V_TOP =
		tndf_pkg::VAL_W'(tndf_pkg::TOP_LIMIT);
	localparam logic signed [tndf_pkg::VAL_W-1:0] V_BOT =
		tndf_pkg::VAL_W'(tndf_pkg::BOTTOM_LIMIT);
	localparam logic signed [tndf_pkg::VAL_W-1:0] V_LOW =
		tndf_pkg::VAL_W'(tndf_pkg::DECIMAL_LOW);

	logic signed [tndf_pkg::VAL_W:0] vx;
	logic [tndf_pkg::VAL_W:0]        mag;
	logic [tndf_pkg::VAL_W:0]        biased;
	logic [31:0]                     prod;
	logic [tndf_pkg::NUM_W-2:0]      q;
	logic signed [tndf_pkg::VAL_W-1:0] limit;
	logic                            in_tenths;

	always_comb begin
		vx        = {value_tenths[tndf_pkg::VAL_W-1], value_tenths};
		limit     = top_row ? V_TOP : V_BOT;
		in_tenths = (value_tenths >= V_LOW) && (value_tenths <= limit);
		mag       = vx[tndf_pkg::VAL_W] ? (17'd0 - 17'(vx)) : 17'(vx);
		// Round half away from zero on the magnitude, then divide by ten
		biased    = mag + 17'(tndf_pkg::ROUND_HALF);
		prod      = 32'(biased[tndf_pkg::VAL_W-1:0]) * 32'd52429;
		q         = 12'(prod >> 19);
		num.top   = top_row;
		num.dot   = in_tenths;
		if (in_tenths) begin
			num.n = tndf_pkg::NUM_W'(value_tenths);
		end else if (vx[tndf_pkg::VAL_W]) begin
			num.n = tndf_pkg::NUM_W'(13'd0 - {1'b0, q});
		end else begin
			num.n = tndf_pkg::NUM_W'({1'b0, q});
		end
	end

endmodule

// ----- hw/rtl/tndf_digits.sv -----
`timescale 1ns / 1ps

module tndf_digits (
	input  tndf_pkg::num_t  num,
	output tndf_pkg::disp_t disp
);

	localparam logic signed [tndf_pkg::NUM_W-1:0] N_TOP =
		tndf_pkg::NUM_W'(tndf_pkg::TOP_LIMIT);
	localparam logic signed [tndf_pkg::NUM_W-1:0] N_BOT =
		tndf_pkg::NUM_W'(tndf_pkg::BOTTOM_LIMIT);
	localparam logic signed [tndf_pkg::NUM_W-1:0] N_LOW =
		tndf_pkg::NUM_W'(tndf_pkg::DECIMAL_LOW);
	localparam logic signed [tndf_pkg::NUM_W-1:0] N_ONE =
		tndf_pkg::NUM_W'(tndf_pkg::ONE_LOW);

	logic signed [tndf_pkg::NUM_W-1:0] limit;
	logic [tndf_pkg::NUM_W-1:0]        mag;
	logic [10:0]                       m;
	logic [26:0]                       p10;
	logic [23:0]                       p100;
	logic [7:0]                        q10;
	logic [4:0]                        h;
	logic [10:0]                       ten_q10;
	logic [7:0]                        ten_h;
	logic [3:0]                        d_right;
	logic [3:0]                        d_mid;
	logic [3:0]                        d_left;

	always_comb begin
		limit   = num.top ? N_TOP : N_BOT;
		mag     = num.n[tndf_pkg::NUM_W-1] ? (13'd0 - 13'(num.n)) : 13'(num.n);
		m       = mag[10:0];
		// Reciprocal multiplies, exact over 0..1999
		p10     = 27'(m) * 27'd52429;
		p100    = 24'(m) * 24'd5243;
		q10     = 8'(p10 >> 19);
		h       = 5'(p100 >> 19);
		ten_q10 = 11'({q10, 3'b000}) + 11'({q10, 1'b0});
		ten_h   = 8'({h, 3'b000}) + 8'({h, 1'b0});
		d_right = 4'(m - ten_q10);
		d_mid   = 4'(q10 - ten_h);
		d_left  = (h >= 5'd10) ? 4'(h - 5'd10) : 4'(h);

		if (num.n < N_LOW) begin
			disp.left   = tndf_pkg::CODE_L;
			disp.middle = tndf_pkg::CODE_O;
			disp.right  = tndf_pkg::CODE_BLANK;
		end else if (num.n > limit) begin
			disp.left   = tndf_pkg::CODE_H;
			disp.middle = tndf_pkg::CODE_I;
			disp.right  = tndf_pkg::CODE_BLANK;
		end else if (num.n[tndf_pkg::NUM_W-1]) begin
			disp.left   = tndf_pkg::CODE_MINUS;
			disp.middle = d_mid;
			disp.right  = d_right;
		end else begin
			disp.left   = (h == 5'd0) ? tndf_pkg::CODE_BLANK : d_left;
			disp.middle = d_mid;
			disp.right  = d_right;
		end

		disp.dot       = num.dot;
		disp.one_on    = num.top && (num.n >= N_ONE) && (num.n <= N_TOP);
		disp.one_write = num.top;
	end

endmodule

// ----- hw/rtl/tenths_number_display_formatter.sv -----
`timescale 1ns / 1ps
// An accepted input transaction is registered in stages 1, 2 and 3 before display.
// Throughput: one transaction per cycle while display is ready; the three register
// stages advance as a stall-aware pipeline, so a full pipe takes an item in every free cycle.
// Reset: arst_n low clears all stage valid bits at once; payload registers are
// not reset. The block is ready as soon as reset is released.

module tenths_number_display_formatter (
	input  logic         clk,
	input  logic         arst_n,
	tndf_in_if.sink      sample,
	tndf_out_if.source   display
);

	// Stage valid bits
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;

	// Stage enables: a stage loads when it is empty or its content moves on
	logic en_s1;
	logic en_s2;
	logic en_s3;

	// Stage 1: captured input transaction
	logic signed [tndf_pkg::VAL_W-1:0] value_s1;
	logic                              top_s1;

	// Stage 2: rounded number, row and dot decision
	tndf_pkg::num_t  num_comb;
	tndf_pkg::num_t  num_s2;

	// Stage 3: formatted row, held until the sink takes it
	tndf_pkg::disp_t disp_comb;
	tndf_pkg::disp_t disp_s3;

	assign en_s3 = !valid_s3 || display.ready;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;

	assign sample.ready = en_s1;

	// Decide tenths versus units and, for units, round the value to whole units
	tndf_round u_round (
		.value_tenths (value_s1),
		.top_row      (top_s1),
		.num          (num_comb)
	);

	// Split the number into cell codes and flags
	tndf_digits u_digits (
		.num  (num_s2),
		.disp (disp_comb)
	);

	// Advance control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= sample.valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Hold payload while a stage is stalled
	always_ff @(posedge clk) begin
		if (en_s1 && sample.valid) begin
			value_s1 <= sample.value_tenths;
			top_s1   <= sample.top_row;
		end
		if (en_s2 && valid_s1) begin
			num_s2 <= num_comb;
		end
		if (en_s3 && valid_s2) begin
			disp_s3 <= disp_comb;
		end
	end

	assign display.valid             = valid_s3;
	assign display.char_left         = disp_s3.left;
	assign display.char_middle       = disp_s3.middle;
	assign display.char_right        = disp_s3.right;
	assign display.dot_on            = disp_s3.dot;
	assign display.leading_one_on    = disp_s3.one_on;
	assign display.leading_one_write = disp_s3.one_write;

	// An accepted transaction always lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> valid_s1)
		else $error("accepted transaction not captured in stage 1");

	// A stalled result is never dropped
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !display.ready |=> valid_s3)
		else $error("stalled result dropped");

	// A value shown in tenths is never out of range
	a_dot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && disp_s3.dot |->
		(disp_s3.left != tndf_pkg::CODE_L) && (disp_s3.left != tndf_pkg::CODE_H))
		else $error("decimal point lit on an out-of-range row");

	// The leading one is only lit on the top row
	a_one_top_only: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && disp_s3.one_on |-> disp_s3.one_write)
		else $error("leading one lit on the bottom row");

endmodule
